[rtl/tga_pkg.sv]
// shared definitions for the tga run-length decoder core
// header offsets, format codes, result kinds and the shared adder width
// no dependencies
`timescale 1ns / 1ps

package tga_pkg;

    // width of the shared add/subtract unit: holds width*height*4
    localparam int ALU_W = 34;

    typedef logic [ALU_W-1:0] t_alu;
    typedef logic [ALU_W:0]   t_alu_res;

    localparam logic [30:0] BUFFER_BYTES_RESET = 31'd1048576;

    // header byte offsets
    localparam logic [4:0] HDR_ID_LEN    = 5'd0;
    localparam logic [4:0] HDR_MAP_TYPE  = 5'd1;
    localparam logic [4:0] HDR_IMG_TYPE  = 5'd2;
    localparam logic [4:0] HDR_WIDTH_LO  = 5'd12;
    localparam logic [4:0] HDR_WIDTH_HI  = 5'd13;
    localparam logic [4:0] HDR_HEIGHT_LO = 5'd14;
    localparam logic [4:0] HDR_HEIGHT_HI = 5'd15;
    localparam logic [4:0] HDR_DEPTH     = 5'd16;
    localparam logic [4:0] HDR_LAST      = 5'd17;

    localparam logic [7:0] TYPE_RAW     = 8'd2;
    localparam logic [7:0] TYPE_RLE     = 8'd10;
    localparam logic [7:0] MAP_NONE     = 8'd0;
    localparam logic [7:0] DEPTH_24     = 8'd24;
    localparam logic [7:0] DEPTH_32     = 8'd32;
    localparam logic [7:0] ALPHA_OPAQUE = 8'd255;

    typedef enum logic [2:0] {
        KIND_PIXELS     = 3'd0,
        KIND_HEADER     = 3'd1,
        KIND_BAD_TYPE   = 3'd2,
        KIND_BAD_FORMAT = 3'd3,
        KIND_SMALL_BUF  = 3'd4
    } t_kind;

    typedef enum logic [4:0] {
        PH_IDLE   = 5'b00001,
        PH_HEADER = 5'b00010,
        PH_IDSKIP = 5'b00100,
        PH_DATA   = 5'b01000,
        PH_DONE   = 5'b10000
    } t_phase;

    typedef enum logic [7:0] {
        S_IDLE = 8'b00000001,
        S_MUL  = 8'b00000010,
        S_CMP  = 8'b00000100,
        S_HDR  = 8'b00001000,
        S_PIX  = 8'b00010000,
        S_SUB  = 8'b00100000,
        S_POS  = 8'b01000000,
        S_WRAP = 8'b10000000
    } t_state;

endpackage

[rtl/tga_addsub.sv]
// shared add/subtract unit of the tga decoder sequencer
// result carries one extra bit: carry on add, borrow on subtract
// depends on tga_pkg
`timescale 1ns / 1ps

module tga_addsub #(
    parameter int W = tga_pkg::ALU_W
) (
    input  logic [W-1:0] i_a,
    input  logic [W-1:0] i_b,
    input  logic         i_sub,
    output logic [W:0]   o_res
);

    always_comb begin
        if (i_sub) begin
            o_res = {1'b0, i_a} - {1'b0, i_b};
        end else begin
            o_res = {1'b0, i_a} + {1'b0, i_b};
        end
    end

endmodule

[rtl/tga_rle_image_decoder_core.sv]
// top level of the tga image decoder (types 2 and 10, 24/32 bpp)
// small sequencer around one shared add/subtract unit
// depends on tga_pkg and tga_addsub
`timescale 1ns / 1ps

// channel   direction  handshake                   payload
// input     in         i_in_valid / o_in_stall     i_data_byte, i_file_start
// output    out        o_out_valid / i_out_stall   o_kind ... o_image_done
// config    in         i_cfg_we                    i_cfg_data (buffer bytes)
//
// most file bytes leave the sequencer idle; a last header byte that passes its
// checks: 16 shift-add steps of width*height, size compare, emit; else only the emit
// a pixel's last byte: emit, subtract, add, then one row crossed per cycle (up to 128)
// reset is synchronous and active low; o_in_stall is high whenever the sequencer is
// busy, and a result waits in its step while a stalled receiver holds the output word

module tga_rle_image_decoder_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [30:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_file_start,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [2:0]  o_kind,
    output logic [15:0] o_start_row,
    output logic [15:0] o_start_column,
    output logic [7:0]  o_pixel_count,
    output logic [7:0]  o_red,
    output logic [7:0]  o_green,
    output logic [7:0]  o_blue,
    output logic [7:0]  o_alpha,
    output logic [15:0] o_image_width,
    output logic [15:0] o_image_height,
    output logic        o_image_done
);

    // sequencer and parse state
    tga_pkg::t_state r_state, n_state;
    tga_pkg::t_phase r_phase, n_phase;
    logic [4:0]  r_hp, n_hp;
    logic [7:0]  r_id_skip, n_id_skip;
    logic        r_rle, n_rle;
    logic        r_d32, n_d32;
    logic        r_type_ok, n_type_ok;
    logic        r_map_ok, n_map_ok;
    logic        r_depth_ok, n_depth_ok;
    logic [15:0] r_cols, n_cols;
    logic [15:0] r_rows, n_rows;
    logic [7:0]  r_pkt_left, n_pkt_left;
    logic        r_pkt_run, n_pkt_run;
    logic [31:0] r_color, n_color;
    logic [1:0]  r_cidx, n_cidx;
    logic [15:0] r_cur_row, n_cur_row;
    logic [15:0] r_cur_col, n_cur_col;
    logic [31:0] r_pix_left, n_pix_left;
    logic [31:0] r_prod, n_prod;
    logic [3:0]  r_iter, n_iter;
    tga_pkg::t_kind r_kind, n_kind;
    logic [7:0]  r_count, n_count;
    logic [16:0] r_pos, n_pos;
    logic [30:0] r_buf, n_buf;

    // output word
    logic           r_o_valid, n_o_valid;
    tga_pkg::t_kind r_o_kind, n_o_kind;
    logic [15:0]    r_o_row, n_o_row;
    logic [15:0]    r_o_col, n_o_col;
    logic [7:0]     r_o_count, n_o_count;
    logic [7:0]     r_o_red, n_o_red;
    logic [7:0]     r_o_green, n_o_green;
    logic [7:0]     r_o_blue, n_o_blue;
    logic [7:0]     r_o_alpha, n_o_alpha;
    logic [15:0]    r_o_w, n_o_w;
    logic [15:0]    r_o_h, n_o_h;
    logic           r_o_done, n_o_done;

    // shared unit
    tga_pkg::t_alu     c_a, c_b;
    logic              c_sub;
    tga_pkg::t_alu_res c_res;

    logic           c_accept;
    logic           c_out_free;
    tga_pkg::t_phase c_ph;
    logic [4:0]     c_hp;
    logic [7:0]     c_count;
    logic           c_last_byte;

    tga_addsub #(
        .W (tga_pkg::ALU_W)
    ) u_addsub (
        .i_a   (c_a),
        .i_b   (c_b),
        .i_sub (c_sub),
        .o_res (c_res)
    );

    assign o_in_stall = (r_state != tga_pkg::S_IDLE);
    assign c_accept   = i_in_valid && (r_state == tga_pkg::S_IDLE);
    // output word can be loaded when empty or being taken now
    assign c_out_free = !r_o_valid || !i_out_stall;

    // a file start restarts the header whatever the phase
    assign c_ph = i_file_start ? tga_pkg::PH_HEADER : r_phase;
    assign c_hp = i_file_start ? tga_pkg::HDR_ID_LEN : r_hp;

    // pixel count of the output word: a run's length clipped to the pixels still missing, else 1
    always_comb begin
        if (r_rle && r_pkt_run) begin
            if ((r_pix_left[31:8] == 24'd0) && (r_pix_left[7:0] < r_pkt_left)) begin
                c_count = r_pix_left[7:0];
            end else begin
                c_count = r_pkt_left;
            end
        end else begin
            c_count = 8'd1;
        end
    end

    assign c_last_byte = r_d32 ? (r_cidx == 2'd3) : (r_cidx == 2'd2);

    // operand selection for the shared unit
    always_comb begin
        c_a   = '0;
        c_b   = '0;
        c_sub = 1'b0;
        case (r_state)
            tga_pkg::S_MUL: begin
                // msb-first shift-add of cols * rows
                c_a = tga_pkg::t_alu'({r_prod[30:0], 1'b0});
                c_b = r_rows[r_iter] ? tga_pkg::t_alu'(r_cols) : '0;
            end
            tga_pkg::S_CMP: begin
                c_a   = tga_pkg::t_alu'(r_buf);
                c_b   = tga_pkg::t_alu'({r_prod, 2'b00});
                c_sub = 1'b1;
            end
            tga_pkg::S_SUB: begin
                c_a   = tga_pkg::t_alu'(r_pix_left);
                c_b   = tga_pkg::t_alu'(r_count);
                c_sub = 1'b1;
            end
            tga_pkg::S_POS: begin
                c_a = tga_pkg::t_alu'(r_cur_col);
                c_b = tga_pkg::t_alu'(r_count);
            end
            tga_pkg::S_WRAP: begin
                c_a   = tga_pkg::t_alu'(r_pos);
                c_b   = tga_pkg::t_alu'(r_cols);
                c_sub = 1'b1;
            end
            default: begin
                c_sub = 1'b0;
            end
        endcase
    end

    always_comb begin
        n_state    = r_state;
        n_phase    = r_phase;
        n_hp       = r_hp;
        n_id_skip  = r_id_skip;
        n_rle      = r_rle;
        n_d32      = r_d32;
        n_type_ok  = r_type_ok;
        n_map_ok   = r_map_ok;
        n_depth_ok = r_depth_ok;
        n_cols     = r_cols;
        n_rows     = r_rows;
        n_pkt_left = r_pkt_left;
        n_pkt_run  = r_pkt_run;
        n_color    = r_color;
        n_cidx     = r_cidx;
        n_cur_row  = r_cur_row;
        n_cur_col  = r_cur_col;
        n_pix_left = r_pix_left;
        n_prod     = r_prod;
        n_iter     = r_iter;
        n_kind     = r_kind;
        n_count    = r_count;
        n_pos      = r_pos;
        n_buf      = i_cfg_we ? i_cfg_data : r_buf;

        n_o_valid = r_o_valid && i_out_stall;
        n_o_kind  = r_o_kind;
        n_o_row   = r_o_row;
        n_o_col   = r_o_col;
        n_o_count = r_o_count;
        n_o_red   = r_o_red;
        n_o_green = r_o_green;
        n_o_blue  = r_o_blue;
        n_o_alpha = r_o_alpha;
        n_o_w     = r_o_w;
        n_o_h     = r_o_h;
        n_o_done  = r_o_done;

        case (r_state)
            tga_pkg::S_IDLE: begin
                if (c_accept) begin
                    if (i_file_start) begin
                        n_phase = tga_pkg::PH_HEADER;
                    end
                    case (c_ph)
                        tga_pkg::PH_HEADER: begin
                            n_hp = c_hp + 5'd1;
                            case (c_hp)
                                tga_pkg::HDR_ID_LEN:    n_id_skip = i_data_byte;
                                tga_pkg::HDR_MAP_TYPE:  n_map_ok = (i_data_byte == tga_pkg::MAP_NONE);
                                tga_pkg::HDR_IMG_TYPE: begin
                                    n_type_ok = (i_data_byte == tga_pkg::TYPE_RAW) ||
                                                (i_data_byte == tga_pkg::TYPE_RLE);
                                    n_rle     = (i_data_byte == tga_pkg::TYPE_RLE);
                                end
                                tga_pkg::HDR_WIDTH_LO:  n_cols[7:0]  = i_data_byte;
                                tga_pkg::HDR_WIDTH_HI:  n_cols[15:8] = i_data_byte;
                                tga_pkg::HDR_HEIGHT_LO: n_rows[7:0]  = i_data_byte;
                                tga_pkg::HDR_HEIGHT_HI: n_rows[15:8] = i_data_byte;
                                tga_pkg::HDR_DEPTH: begin
                                    n_depth_ok = (i_data_byte == tga_pkg::DEPTH_24) ||
                                                 (i_data_byte == tga_pkg::DEPTH_32);
                                    n_d32      = (i_data_byte == tga_pkg::DEPTH_32);
                                end
                                tga_pkg::HDR_LAST: begin
                                    if (!r_type_ok) begin
                                        n_kind  = tga_pkg::KIND_BAD_TYPE;
                                        n_phase = tga_pkg::PH_DONE;
                                        n_state = tga_pkg::S_HDR;
                                    end else if (!r_map_ok || !r_depth_ok) begin
                                        n_kind  = tga_pkg::KIND_BAD_FORMAT;
                                        n_phase = tga_pkg::PH_DONE;
                                        n_state = tga_pkg::S_HDR;
                                    end else begin
                                        n_prod  = '0;
                                        n_iter  = 4'd15;
                                        n_state = tga_pkg::S_MUL;
                                    end
                                end
                                default: begin
                                    n_hp = c_hp + 5'd1;
                                end
                            endcase
                        end
                        tga_pkg::PH_IDSKIP: begin
                            n_id_skip = r_id_skip - 8'd1;
                            if (r_id_skip == 8'd1) begin
                                n_phase = tga_pkg::PH_DATA;
                            end
                        end
                        tga_pkg::PH_DATA: begin
                            if (r_rle && (r_pkt_left == 8'd0)) begin
                                // packet header byte
                                n_pkt_left = {1'b0, i_data_byte[6:0]} + 8'd1;
                                n_pkt_run  = i_data_byte[7];
                                n_cidx     = 2'd0;
                            end else begin
                                n_color[8*r_cidx +: 8] = i_data_byte;
                                if (c_last_byte) begin
                                    n_cidx  = 2'd0;
                                    n_state = tga_pkg::S_PIX;
                                end else begin
                                    n_cidx = r_cidx + 2'd1;
                                end
                            end
                        end
                        default: begin
                            n_hp = r_hp;
                        end
                    endcase
                end
            end
            tga_pkg::S_MUL: begin
                n_prod = c_res[31:0];
                if (r_iter == 4'd0) begin
                    n_state = tga_pkg::S_CMP;
                end else begin
                    n_iter = r_iter - 4'd1;
                end
            end
            tga_pkg::S_CMP: begin
                n_state = tga_pkg::S_HDR;
                if (c_res[tga_pkg::ALU_W]) begin
                    // buffer smaller than width*height*4
                    n_kind  = tga_pkg::KIND_SMALL_BUF;
                    n_phase = tga_pkg::PH_DONE;
                end else begin
                    n_kind     = tga_pkg::KIND_HEADER;
                    n_pix_left = r_prod;
                    n_cur_row  = (r_rows != 16'd0) ? (r_rows - 16'd1) : 16'd0;
                    n_cur_col  = 16'd0;
                    n_pkt_left = 8'd0;
                    n_cidx     = 2'd0;
                    n_color    = '0;
                    if (r_prod == 32'd0) begin
                        n_phase = tga_pkg::PH_DONE;
                    end else if (r_id_skip != 8'd0) begin
                        n_phase = tga_pkg::PH_IDSKIP;
                    end else begin
                        n_phase = tga_pkg::PH_DATA;
                    end
                end
            end
            tga_pkg::S_HDR: begin
                if (c_out_free) begin
                    n_o_valid = 1'b1;
                    n_o_kind  = r_kind;
                    n_o_row   = '0;
                    n_o_col   = '0;
                    n_o_count = '0;
                    n_o_red   = '0;
                    n_o_green = '0;
                    n_o_blue  = '0;
                    n_o_alpha = '0;
                    if ((r_kind == tga_pkg::KIND_HEADER) ||
                        (r_kind == tga_pkg::KIND_SMALL_BUF)) begin
                        n_o_w = r_cols;
                        n_o_h = r_rows;
                    end else begin
                        n_o_w = '0;
                        n_o_h = '0;
                    end
                    n_o_done = (r_kind == tga_pkg::KIND_HEADER) && (r_pix_left == 32'd0);
                    n_state  = tga_pkg::S_IDLE;
                end
            end
            tga_pkg::S_PIX: begin
                if (c_out_free) begin
                    n_o_valid = 1'b1;
                    n_o_kind  = tga_pkg::KIND_PIXELS;
                    n_o_row   = r_cur_row;
                    n_o_col   = r_cur_col;
                    n_o_count = c_count;
                    n_o_red   = r_color[23:16];
                    n_o_green = r_color[15:8];
                    n_o_blue  = r_color[7:0];
                    n_o_alpha = r_d32 ? r_color[31:24] : tga_pkg::ALPHA_OPAQUE;
                    n_o_w     = '0;
                    n_o_h     = '0;
                    n_o_done  = (r_pix_left == {24'd0, c_count});
                    if (r_pix_left == {24'd0, c_count}) begin
                        n_phase = tga_pkg::PH_DONE;
                    end
                    n_count = c_count;
                    if (r_rle) begin
                        n_pkt_left = r_pkt_run ? 8'd0 : (r_pkt_left - 8'd1);
                    end
                    n_state = tga_pkg::S_SUB;
                end
            end
            tga_pkg::S_SUB: begin
                n_pix_left = c_res[31:0];
                n_state    = (r_cols == 16'd0) ? tga_pkg::S_IDLE : tga_pkg::S_POS;
            end
            tga_pkg::S_POS: begin
                n_pos   = c_res[16:0];
                n_state = tga_pkg::S_WRAP;
            end
            tga_pkg::S_WRAP: begin
                // one row crossed per cycle until the column fits
                if (!c_res[tga_pkg::ALU_W]) begin
                    n_pos     = c_res[16:0];
                    n_cur_row = r_cur_row - 16'd1;
                end else begin
                    n_cur_col = r_pos[15:0];
                    n_state   = tga_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = tga_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= tga_pkg::S_IDLE;
            r_phase   <= tga_pkg::PH_IDLE;
            r_hp      <= '0;
            r_buf     <= tga_pkg::BUFFER_BYTES_RESET;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_phase   <= n_phase;
            r_hp      <= n_hp;
            r_buf     <= n_buf;
            r_o_valid <= n_o_valid;
        end
    end

    // payload and working registers, no reset needed
    always_ff @(posedge i_clk) begin
        r_id_skip  <= n_id_skip;
        r_rle      <= n_rle;
        r_d32      <= n_d32;
        r_type_ok  <= n_type_ok;
        r_map_ok   <= n_map_ok;
        r_depth_ok <= n_depth_ok;
        r_cols     <= n_cols;
        r_rows     <= n_rows;
        r_pkt_left <= n_pkt_left;
        r_pkt_run  <= n_pkt_run;
        r_color    <= n_color;
        r_cidx     <= n_cidx;
        r_cur_row  <= n_cur_row;
        r_cur_col  <= n_cur_col;
        r_pix_left <= n_pix_left;
        r_prod     <= n_prod;
        r_iter     <= n_iter;
        r_kind     <= n_kind;
        r_count    <= n_count;
        r_pos      <= n_pos;
        r_o_kind   <= n_o_kind;
        r_o_row    <= n_o_row;
        r_o_col    <= n_o_col;
        r_o_count  <= n_o_count;
        r_o_red    <= n_o_red;
        r_o_green  <= n_o_green;
        r_o_blue   <= n_o_blue;
        r_o_alpha  <= n_o_alpha;
        r_o_w      <= n_o_w;
        r_o_h      <= n_o_h;
        r_o_done   <= n_o_done;
    end

    assign o_out_valid    = r_o_valid;
    assign o_kind         = r_o_kind;
    assign o_start_row    = r_o_row;
    assign o_start_column = r_o_col;
    assign o_pixel_count  = r_o_count;
    assign o_red          = r_o_red;
    assign o_green        = r_o_green;
    assign o_blue         = r_o_blue;
    assign o_alpha        = r_o_alpha;
    assign o_image_width  = r_o_w;
    assign o_image_height = r_o_h;
    assign o_image_done   = r_o_done;

endmodule
